// File: src/bitpacked_value_unpacker_unit_assert.svh
// Assertion macros for the bit unpacker modules.
// Needs a clk and an active-low arst_n in the including module.
`ifndef BITPACKED_VALUE_UNPACKER_UNIT_ASSERT_SVH
`define BITPACKED_VALUE_UNPACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define BVU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BVU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bvu_pkg.sv
// Package for the bit unpacker: controller states, command/status structs, constants.
// No dependencies.
`timescale 1ns / 1ps

package bvu_pkg;

	localparam logic [5:0] WORD_BITS  = 6'd32;
	localparam logic [5:0] WIDTH_MIN  = 6'd1;
	localparam logic [5:0] WIDTH_MAX  = 6'd32;
	localparam logic [5:0] WIDTH_RST  = 6'd32;
	localparam logic [4:0] BLOCK_LAST = 5'd31;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_sts_t;

endpackage

// File: src/bvu_ctrl.sv
// Bit unpacker controller: accept/emit state machine and output valid flag.
// Depends on bvu_pkg and bitpacked_value_unpacker_unit_assert.svh.
`timescale 1ns / 1ps
`include "bitpacked_value_unpacker_unit_assert.svh"

module bvu_ctrl
	import bvu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.pop && sts.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.pop  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EMIT: begin
				cmd.pop = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`BVU_ASSERT_NEXT(a_last_pop_frees_input, cmd.pop && sts.last, in_ready, "input not free after last value")
	`BVU_ASSERT_NEXT(a_pop_fills_output, cmd.pop, out_valid, "popped value not presented")
	`BVU_ASSERT_NEXT(a_load_blocks_input, cmd.load, !in_ready, "input taken while word in work")

endmodule

// File: src/bvu_dp.sv
// Bit unpacker datapath: width register, 63-bit bit buffer, block index, output register.
// Depends on bvu_pkg and bitpacked_value_unpacker_unit_assert.svh.
`timescale 1ns / 1ps
`include "bitpacked_value_unpacker_unit_assert.svh"

module bvu_dp
	import bvu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [31:0] packed_word,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data,
	output logic [5:0]  width,
	output logic [31:0] value,
	output logic        last_of_word,
	output logic        block_end
);

	logic [5:0]  width_q;
	logic [62:0] buf_q;
	logic [5:0]  held_q;
	logic [4:0]  idx_q;
	logic [31:0] value_q;
	logic        last_q;
	logic        bend_q;
	logic [31:0] mask;
	logic        cfg_ok;

	assign cfg_ok   = cfg_we && (cfg_data >= WIDTH_MIN) && (cfg_data <= WIDTH_MAX);
	assign mask     = 32'hFFFF_FFFF >> (WORD_BITS - width_q);
	assign sts.last = {1'b0, held_q} < {width_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			buf_q   <= '0;
			held_q  <= '0;
			idx_q   <= '0;
		end else if (cfg_ok) begin
			width_q <= cfg_data;
			buf_q   <= '0;
			held_q  <= '0;
			idx_q   <= '0;
		end else if (cmd.load) begin
			buf_q  <= buf_q | ({31'b0, packed_word} << held_q[4:0]);
			held_q <= held_q + WORD_BITS;
		end else if (cmd.pop) begin
			buf_q  <= buf_q >> width_q;
			held_q <= held_q - width_q;
			idx_q  <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			value_q <= buf_q[31:0] & mask;
			last_q  <= sts.last;
			bend_q  <= (idx_q == BLOCK_LAST);
		end
	end

	assign width        = width_q;
	assign value        = value_q;
	assign last_of_word = last_q;
	assign block_end    = bend_q;

	`BVU_ASSERT_NEXT(a_load_gives_value, cmd.load, held_q >= width_q, "word left too few bits")
	`BVU_ASSERT_NOW(a_width_legal, 1'b1, (width_q >= WIDTH_MIN) && (width_q <= WIDTH_MAX), "width out of range")
	`BVU_ASSERT_NEXT(a_cfg_clears, cfg_ok, (held_q == '0) && (idx_q == '0), "write kept stream")

endmodule

// File: src/bitpacked_value_unpacker_unit.sv
// Bit unpacker top level: APB register decode, controller and datapath.
// Depends on bvu_pkg, bvu_ctrl, bvu_dp.
//
//  channel  | signals                                  | role
//  ---------+------------------------------------------+-------------------------------
//  in       | in_valid, in_ready, packed_word          | 32-bit packed words
//  out      | out_valid, out_ready, value, last_of_word, block_end | unpacked values
//  apb      | psel, penable, pwrite, paddr, pwdata, prdata, pready | value_width at 0x0
//
// A word is taken in, then yields floor((held + 32) / width) values, one per cycle while the
// output is not stalled; width 1 yields 32 values per word.
// The single-ported bit buffer alternates between word load and value extraction.
// Reset: width 32, buffer and block position empty. A legal width write also empties them.
// An output stall holds the output register and pauses extraction; input is taken
// again once the last value of the word has moved into the output register.
`timescale 1ns / 1ps

module bitpacked_value_unpacker_unit
	import bvu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] packed_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        last_of_word,
	output logic        block_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic       cfg_we;
	logic [5:0] width;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'h0 : {26'b0, width};

	bvu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bvu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.packed_word  (packed_word),
		.cfg_we       (cfg_we),
		.cfg_data     (pwdata[5:0]),
		.width        (width),
		.value        (value),
		.last_of_word (last_of_word),
		.block_end    (block_end)
	);

endmodule

// File: tb/sv/bitpacked_value_unpacker_unit_tb.sv
// Self-checking testbench for bitpacked_value_unpacker_unit: packed words in, unpacked values out.
// Keeps a shadow of the bit buffer to predict every value; drives the APB width register.
// Depends on bvu_pkg and the unit under test.
`timescale 1ns / 1ps

module bitpacked_value_unpacker_unit_tb;
	import bvu_pkg::*;

	localparam logic [2:0] ADDR_VALUE_WIDTH = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
	localparam int         DRAIN_CYCLES     = 40;
	localparam int         HOLD_CYCLES      = 300;

	typedef struct packed {
		logic [31:0] value;
		logic        last_of_word;
		logic        block_end;
	} unpacked_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] packed_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] value;
	logic        last_of_word;
	logic        block_end;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the unit state
	logic [5:0]  shadow_width;
	logic [62:0] shadow_bits;
	logic [5:0]  shadow_held;
	logic [4:0]  shadow_pos;

	unpacked_t   expected_values[$];
	int          errors       = 0;
	bit          tx_gaps      = 1'b1;
	bit          rx_gaps      = 1'b1;
	bit          hold_request = 1'b0;
	int          rx_stall_left = 0;

	always #6 clk = ~clk;

	bitpacked_value_unpacker_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_word  (packed_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value),
		.last_of_word (last_of_word),
		.block_end    (block_end),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	function automatic void clear_shadow_stream();
		shadow_bits = '0;
		shadow_held = '0;
		shadow_pos  = '0;
	endfunction

	function automatic void apply_reg_write(input logic [2:0] addr, input logic [31:0] data);
		if (addr == ADDR_VALUE_WIDTH && data[5:0] >= WIDTH_MIN && data[5:0] <= WIDTH_MAX) begin
			shadow_width = data[5:0];
			clear_shadow_stream();
		end
	endfunction

	// append one word to the shadow buffer and queue every value it releases
	function automatic void unpack_word(input logic [31:0] word);
		logic [5:0]  wd;
		logic [63:0] merged;
		logic [63:0] mask;
		unpacked_t   item;
		int          n;
		wd = shadow_width;
		if (wd < WIDTH_MIN || wd > WIDTH_MAX)
			wd = WIDTH_MAX;
		if (shadow_held >= wd)
			clear_shadow_stream();
		mask        = (64'd1 << wd) - 64'd1;
		merged      = {1'b0, shadow_bits} | ({32'd0, word} << shadow_held);
		shadow_bits = merged[62:0];
		shadow_held = shadow_held + WORD_BITS;
		n = 0;
		while (shadow_held >= wd && n < 32) begin
			item.value     = shadow_bits[31:0] & mask[31:0];
			item.block_end = (shadow_pos == BLOCK_LAST);
			shadow_pos     = shadow_pos + 5'd1;
			shadow_bits    = shadow_bits >> wd;
			shadow_held    = shadow_held - wd;
			n++;
			item.last_of_word = !(shadow_held >= wd && n < 32);
			expected_values.push_back(item);
		end
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [31:0] word);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		packed_word <= word;
		do @(posedge clk); while (!in_ready);
		unpack_word(word);
	endtask

	task automatic drain_stream();
		in_valid <= 1'b0;
		while (expected_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		apply_reg_write(addr, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_width_reg();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_VALUE_WIDTH;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {26'd0, shadow_width}) begin
			$display("%0t: value_width read, expected %0d, actual %0d",
				$time, shadow_width, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_width();
		check_width_reg();
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0001);
		send_word(random_word());
		drain_stream();
	endtask

	task automatic test_width_extremes();
		write_reg(ADDR_VALUE_WIDTH, {26'd0, WIDTH_MIN});
		check_width_reg();
		send_word(32'hAAAA_AAAA);
		send_word(32'h0000_0001);
		drain_stream();
		write_reg(ADDR_VALUE_WIDTH, 32'd31);
		check_width_reg();
		repeat (3) send_word(random_word());
		drain_stream();
		write_reg(ADDR_VALUE_WIDTH, {26'd0, WIDTH_MAX});
		send_word(32'h1234_5678);
		drain_stream();
	endtask

	// illegal widths and unmapped writes keep the width and the partial buffer
	task automatic test_ignored_writes();
		write_reg(ADDR_VALUE_WIDTH, 32'd5);
		repeat (3) send_word(random_word());
		drain_stream();
		write_reg(ADDR_VALUE_WIDTH, 32'd0);
		write_reg(ADDR_VALUE_WIDTH, 32'd33);
		write_reg(ADDR_VALUE_WIDTH, 32'd63);
		write_reg(ADDR_VALUE_WIDTH, 32'h0000_0040);
		write_reg(ADDR_UNMAPPED, 32'd7);
		check_width_reg();
		repeat (2) send_word(random_word());
		drain_stream();
		// only the low six bits select the width
		write_reg(ADDR_VALUE_WIDTH, 32'hFFFF_FFC7);
		check_width_reg();
		repeat (2) send_word(random_word());
		drain_stream();
	endtask

	task automatic test_random_stream();
		logic [31:0] data;
		for (int ph = 0; ph < 10; ph++) begin
			data = $urandom();
			case (ph)
				0:       data[5:0] = WIDTH_MIN;
				1:       data[5:0] = WIDTH_MAX;
				default: data[5:0] = $urandom_range(1, 32);
			endcase
			write_reg(ADDR_VALUE_WIDTH, data);
			check_width_reg();
			repeat (20) send_word(random_word());
			drain_stream();
			case ($urandom_range(0, 2))
				0:       write_reg(ADDR_VALUE_WIDTH, {$urandom_range(0, 3) << 6}
						| ($urandom_range(0, 1) ? 32'd0 : $urandom_range(33, 63)));
				1:       write_reg(ADDR_UNMAPPED, $urandom());
				default: ;
			endcase
			repeat (20) send_word(random_word());
			drain_stream();
		end
	endtask

	task automatic test_output_backpressure();
		write_reg(ADDR_VALUE_WIDTH, 32'd3);
		hold_request = 1'b1;
		repeat (20) send_word(random_word());
		drain_stream();
	endtask

	task automatic test_full_rate();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_reg(ADDR_VALUE_WIDTH, 32'd9);
		repeat (20) send_word(random_word());
		drain_stream();
		write_reg(ADDR_VALUE_WIDTH, {26'd0, WIDTH_MIN});
		repeat (20) send_word(random_word());
		drain_stream();
	endtask

	// receiver: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (rx_stall_left != 0) begin
			rx_stall_left--;
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request  = 1'b0;
			rx_stall_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			rx_stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_output
		unpacked_t got;
		unpacked_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{value, last_of_word, block_end};
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual value %h last %b end %b",
					$time, value, last_of_word, block_end);
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (got !== want) begin
					$display("%0t: expected value %h last %b end %b, actual value %h last %b end %b",
						$time, want.value, want.last_of_word, want.block_end,
						got.value, got.last_of_word, got.block_end);
					errors++;
				end
			end
		end
	end

	initial begin
		#12_000_000;
		$display("[bitpacked_value_unpacker_unit] ERROR");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		packed_word = '0;
		out_ready   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		shadow_width = WIDTH_RST;
		clear_shadow_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_width_extremes();
		test_ignored_writes();
		test_random_stream();
		test_output_backpressure();
		test_full_rate();
		if (errors == 0)
			$display("[bitpacked_value_unpacker_unit] OK");
		else
			$display("[bitpacked_value_unpacker_unit] ERROR");
		$finish;
	end

endmodule
